[rtl/sitda_pkg.sv]
// shared constants for the signed integer to decimal text converter
package sitda_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;

  localparam int CHAR_WIDTH      = 6;
  localparam int OUT_TDATA_WIDTH = 8;

  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 6'd57;

  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

endpackage

[rtl/signed_int_to_decimal_ascii.sv]
// signed integer to decimal ascii text, bit-serial double dabble then digit emission
//
// Input stream s_axis: one request carries one two's complement value in the low
// VALUE_WIDTH bits of tdata. Output stream m_axis: one character per transfer,
// '-' first for negative values, then the decimal digits with no leading zeros;
// tlast marks the final character of each number. Zero gives a single '0'.
//
// Timing: the magnitude is shifted into a BCD register one bit per cycle.
// Then, after the '-' when negative, the BCD register is shifted out one
// digit per cycle, skipping leading zeros, while the receiver is not stalling.
// The next value is accepted as soon as the last character is in the output
// register, while that character still waits to be taken.
//
// Reset clears the control state and drops any pending character. When the
// receiver stalls, the output register holds its character and the digit
// sequencer waits; no character is lost or repeated.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // value
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // character, then zero fill
  output logic [sitda_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  localparam int NDIG      = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W     = NDIG * 4;
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W = $clog2(NDIG + 1);
  localparam int CW        = sitda_pkg::CHAR_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bcd;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_cnt;
  logic                   negative;
  logic [CW-1:0]          character;

  logic [VALUE_WIDTH-1:0] raw;
  logic                   raw_neg;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [BCD_W-1:0]       bcd_adj;
  logic [3:0]             top_digit;
  logic                   out_free;
  logic                   out_load;

  assign raw       = s_axis_tdata[VALUE_WIDTH-1:0];
  assign raw_neg   = raw[VALUE_WIDTH-1];
  // magnitude taken unsigned, so the most negative value needs no special path
  assign mag_in    = raw_neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
  assign top_digit = bcd[BCD_W-1 -: 4];
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign out_load  = out_free && (state == ST_SIGN || state == ST_EMIT);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {{(sitda_pkg::OUT_TDATA_WIDTH-CW){1'b0}}, character};

  // add-3 on every digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= sitda_pkg::BCD_ADJ_LIMIT) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + sitda_pkg::BCD_ADJ_ADD;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
      bit_cnt       <= '0;
      dig_cnt       <= '0;
      negative      <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mag      <= mag_in;
            negative <= raw_neg;
            bcd      <= '0;
            bit_cnt  <= BIT_CNT_W'(VALUE_WIDTH - 1);
            dig_cnt  <= DIG_CNT_W'(NDIG);
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
          mag     <= {mag[VALUE_WIDTH-2:0], 1'b0};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= negative ? ST_SIGN : ST_SKIP;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            character     <= sitda_pkg::CH_MINUS;
            m_axis_tlast  <= 1'b0;
            state         <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, keeping at least one digit
          if (top_digit == 4'd0 && dig_cnt != DIG_CNT_W'(1)) begin
            bcd     <= {bcd[BCD_W-5:0], 4'd0};
            dig_cnt <= dig_cnt - 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            character     <= sitda_pkg::CH_ZERO + {{(CW-4){1'b0}}, top_digit};
            m_axis_tlast  <= (dig_cnt == DIG_CNT_W'(1));
            bcd           <= {bcd[BCD_W-5:0], 4'd0};
            dig_cnt       <= dig_cnt - 1'b1;
            if (dig_cnt == DIG_CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (character == sitda_pkg::CH_MINUS ||
                       (character >= sitda_pkg::CH_ZERO && character <= sitda_pkg::CH_NINE)))
    else $error("character outside the decimal text set");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && character == sitda_pkg::CH_MINUS) |-> !m_axis_tlast)
    else $error("minus sign flagged as last character");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_CONV))
    else $error("accepted value did not start conversion");

  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_EMIT) |-> (dig_cnt != '0))
    else $error("digit sequencer ran out of digits");

  a_no_output_in_conv: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |=> !$rose(m_axis_tvalid))
    else $error("character produced during conversion");

endmodule
